// ===== src/ise_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ise_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 4;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 4'd0;
    localparam logic [OP_W-1:0] OP_POP    = 4'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 4'd3;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd4;
    localparam logic [OP_W-1:0] OP_SWAP   = 4'd5;
    localparam logic [OP_W-1:0] OP_DUP    = 4'd6;
    localparam logic [OP_W-1:0] OP_SEARCH = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR  = 4'd8;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_A,
        S_READ_B,
        S_SWAP_WR,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        WD_OPERAND,
        WD_RDATA,
        WD_SUM,
        WD_DIFF,
        WD_HOLD
    } wsel_t;

    typedef enum logic [2:0] {
        ADR_TOP,
        ADR_NEXT,
        ADR_SECOND,
        ADR_ZERO,
        ADR_SCAN
    } addr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        logic             capture;
        logic             mem_we;
        wsel_t            wsel;
        addr_sel_t        waddr_sel;
        logic             mem_re;
        addr_sel_t        raddr_sel;
        cnt_op_t          cnt_op;
        logic             set_status;
        logic [ST_W-1:0]  status_code;
        logic             set_rd;
        logic             set_found;
        logic             hold_a;
        logic             idx_clr;
        logic             idx_inc;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            below_two;
        logic            full;
        logic            hit;
        logic            scan_last;
        logic            out_busy;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/integer_stack_engine_core.sv =====
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_req_type, s_operand
// m_       out        m_valid / m_ready   m_read_data, m_found, m_status,
//                                         m_is_empty, m_fill_count
//
// One transaction in flight: push, clear and any error pass from DECODE to
// DONE; pop, peek, add, subtract and duplicate add READ_A; swap READ_A,
// READ_B and SWAP_WR; search reads k entries in SCAN (k at most DEPTH).
// Synchronous active-low reset empties the stack; RAM contents are kept.
// A stalled result holds in the output register; the next transaction is
// still accepted and waits in the final state until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module integer_stack_engine_core
    import ise_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic        [OP_W-1:0]   s_req_type,
    input  wire logic signed [DATA_W-1:0] s_operand,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed      [DATA_W-1:0] m_read_data,
    output logic                          m_found,
    output logic             [ST_W-1:0]   m_status,
    output logic                          m_is_empty,
    output logic             [CNT_W-1:0]  m_fill_count
);

    cmd_t cmd;
    sts_t sts;

    ise_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ise_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_req_type   (s_req_type),
        .s_operand    (s_operand),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_found      (m_found),
        .m_status     (m_status),
        .m_is_empty   (m_is_empty),
        .m_fill_count (m_fill_count)
    );

endmodule

`default_nettype wire

// ===== src/ise_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ise_ctrl
    import ise_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   dec_err;
    logic   dec_read;
    logic   dec_scan;
    logic [ST_W-1:0] dec_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        dec_err  = 1'b0;
        dec_read = 1'b0;
        dec_scan = 1'b0;
        dec_code = ST_OK;
        case (sts.op)
            OP_PUSH: begin
                if (sts.full) begin
                    dec_err  = 1'b1;
                    dec_code = ST_OVERFLOW;
                end
            end
            OP_POP, OP_PEEK, OP_ADD, OP_SUB: begin
                if (sts.empty) begin
                    dec_err  = 1'b1;
                    dec_code = ST_UNDERFLOW;
                end else begin
                    dec_read = 1'b1;
                end
            end
            OP_SWAP: begin
                if (sts.below_two) begin
                    dec_err  = 1'b1;
                    dec_code = ST_UNDERFLOW;
                end else begin
                    dec_read = 1'b1;
                end
            end
            OP_DUP: begin
                if (sts.empty) begin
                    dec_err  = 1'b1;
                    dec_code = ST_UNDERFLOW;
                end else if (sts.full) begin
                    dec_err  = 1'b1;
                    dec_code = ST_OVERFLOW;
                end else begin
                    dec_read = 1'b1;
                end
            end
            OP_SEARCH: begin
                dec_scan = !sts.empty;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (dec_read)      state_next = S_READ_A;
                else if (dec_scan) state_next = S_SCAN;
                else               state_next = S_DONE;
            end
            S_READ_A: begin
                if (sts.op == OP_SWAP) state_next = S_READ_B;
                else                   state_next = S_DONE;
            end
            S_READ_B:  state_next = S_SWAP_WR;
            S_SWAP_WR: state_next = S_DONE;
            S_SCAN: begin
                if (sts.hit || sts.scan_last) state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.wsel    = WD_OPERAND;
        cmd.waddr_sel = ADR_TOP;
        cmd.raddr_sel = ADR_TOP;
        cmd.cnt_op  = CNT_HOLD;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_DECODE: begin
                if (dec_err) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = dec_code;
                end else if (dec_read) begin
                    cmd.mem_re    = 1'b1;
                    cmd.raddr_sel = ADR_TOP;
                end else if (dec_scan) begin
                    cmd.mem_re    = 1'b1;
                    cmd.raddr_sel = ADR_ZERO;
                    cmd.idx_clr   = 1'b1;
                end else if (sts.op == OP_PUSH) begin
                    cmd.mem_we    = 1'b1;
                    cmd.wsel      = WD_OPERAND;
                    cmd.waddr_sel = ADR_NEXT;
                    cmd.cnt_op    = CNT_INC;
                end else if (sts.op == OP_CLEAR) begin
                    cmd.cnt_op = CNT_CLR;
                end
            end
            S_READ_A: begin
                case (sts.op)
                    OP_POP: begin
                        cmd.set_rd = 1'b1;
                        cmd.cnt_op = CNT_DEC;
                    end
                    OP_PEEK: cmd.set_rd = 1'b1;
                    OP_ADD: begin
                        cmd.mem_we    = 1'b1;
                        cmd.wsel      = WD_SUM;
                        cmd.waddr_sel = ADR_TOP;
                    end
                    OP_SUB: begin
                        cmd.mem_we    = 1'b1;
                        cmd.wsel      = WD_DIFF;
                        cmd.waddr_sel = ADR_TOP;
                    end
                    OP_DUP: begin
                        cmd.mem_we    = 1'b1;
                        cmd.wsel      = WD_RDATA;
                        cmd.waddr_sel = ADR_NEXT;
                        cmd.cnt_op    = CNT_INC;
                    end
                    OP_SWAP: begin
                        cmd.hold_a    = 1'b1;
                        cmd.mem_re    = 1'b1;
                        cmd.raddr_sel = ADR_SECOND;
                    end
                    default: begin
                    end
                endcase
            end
            S_READ_B: begin
                cmd.mem_we    = 1'b1;
                cmd.wsel      = WD_RDATA;
                cmd.waddr_sel = ADR_TOP;
            end
            S_SWAP_WR: begin
                cmd.mem_we    = 1'b1;
                cmd.wsel      = WD_HOLD;
                cmd.waddr_sel = ADR_SECOND;
            end
            S_SCAN: begin
                if (sts.hit) begin
                    cmd.set_found = 1'b1;
                end else if (!sts.scan_last) begin
                    cmd.mem_re    = 1'b1;
                    cmd.raddr_sel = ADR_SCAN;
                    cmd.idx_inc   = 1'b1;
                end
            end
            S_DONE: begin
                cmd.load_out = !sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ise_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ise_datapath
    import ise_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cmd_t                     cmd,
    output sts_t                          sts,
    input  wire logic        [OP_W-1:0]   s_req_type,
    input  wire logic signed [DATA_W-1:0] s_operand,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed      [DATA_W-1:0] m_read_data,
    output logic                          m_found,
    output logic             [ST_W-1:0]   m_status,
    output logic                          m_is_empty,
    output logic             [CNT_W-1:0]  m_fill_count
);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] operand_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] hold_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic              res_found_reg;
    logic [ST_W-1:0]   res_status_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_found_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic [CNT_W-1:0]  m_count_reg;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [ADDR_W-1:0] adr_top;
    logic [ADDR_W-1:0] adr_next;
    logic [ADDR_W-1:0] adr_second;
    logic [ADDR_W-1:0] adr_scan;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [DATA_W-1:0] wdata;

    assign cnt_m1     = count_reg - CNT_W'(1);
    assign cnt_m2     = count_reg - CNT_W'(2);
    assign adr_top    = cnt_m1[ADDR_W-1:0];
    assign adr_next   = count_reg[ADDR_W-1:0];
    assign adr_second = cnt_m2[ADDR_W-1:0];
    assign adr_scan   = idx_reg + ADDR_W'(1);

    function automatic logic [ADDR_W-1:0] pick_addr(
        input addr_sel_t       sel,
        input logic [ADDR_W-1:0] top,
        input logic [ADDR_W-1:0] nxt,
        input logic [ADDR_W-1:0] sec,
        input logic [ADDR_W-1:0] scan
    );
        logic [ADDR_W-1:0] a;
        case (sel)
            ADR_TOP:    a = top;
            ADR_NEXT:   a = nxt;
            ADR_SECOND: a = sec;
            ADR_SCAN:   a = scan;
            default:    a = '0;
        endcase
        return a;
    endfunction

    assign waddr = pick_addr(cmd.waddr_sel, adr_top, adr_next, adr_second, adr_scan);
    assign raddr = pick_addr(cmd.raddr_sel, adr_top, adr_next, adr_second, adr_scan);

    always_comb begin
        case (cmd.wsel)
            WD_OPERAND: wdata = operand_reg;
            WD_RDATA:   wdata = rdata_reg;
            WD_SUM:     wdata = rdata_reg + operand_reg;
            WD_DIFF:    wdata = rdata_reg - operand_reg;
            WD_HOLD:    wdata = hold_reg;
            default:    wdata = operand_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.cnt_op)
                CNT_INC:  count_reg <= count_reg + CNT_W'(1);
                CNT_DEC:  count_reg <= cnt_m1;
                CNT_CLR:  count_reg <= '0;
                default:  count_reg <= count_reg;
            endcase
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= adr_scan;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg         <= s_req_type;
            operand_reg    <= s_operand;
            res_data_reg   <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= ST_OK;
        end else begin
            if (cmd.set_rd)     res_data_reg   <= rdata_reg;
            if (cmd.set_found)  res_found_reg  <= 1'b1;
            if (cmd.set_status) res_status_reg <= cmd.status_code;
        end
        if (cmd.hold_a) begin
            hold_reg <= rdata_reg;
        end
        if (cmd.load_out) begin
            m_data_reg   <= res_data_reg;
            m_found_reg  <= res_found_reg;
            m_status_reg <= res_status_reg;
            m_count_reg  <= count_reg;
        end
    end

    always_comb begin
        sts.op        = op_reg;
        sts.empty     = (count_reg == '0);
        sts.below_two = (count_reg < CNT_W'(2));
        sts.full      = (count_reg >= CNT_W'(DEPTH));
        sts.hit       = (rdata_reg == operand_reg);
        sts.scan_last = (idx_reg == adr_top);
        sts.out_busy  = m_valid_reg && !m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_data_reg;
    assign m_found      = m_found_reg;
    assign m_status     = m_status_reg;
    assign m_is_empty   = (m_count_reg == '0);
    assign m_fill_count = m_count_reg;

endmodule

`default_nettype wire

// ===== src/ise_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ise_checker
    import ise_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic signed [DATA_W-1:0] m_read_data,
    input wire logic                     m_found,
    input wire logic        [ST_W-1:0]   m_status,
    input wire logic                     m_is_empty,
    input wire logic        [CNT_W-1:0]  m_fill_count
);

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fill_count <= CNT_W'(DEPTH)))
        else $error("fill count beyond capacity");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_status == ST_OK && m_read_data == '0))
        else $error("search hit with error or data");

    a_error_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_OVERFLOW || m_status == ST_UNDERFLOW))
            |-> (m_read_data == '0 && !m_found))
        else $error("failed transaction carries data");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_data)
            && $stable(m_status) && $stable(m_fill_count)))
        else $error("stalled result changed");

endmodule

bind integer_stack_engine_core ise_checker u_ise_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_found      (m_found),
    .m_status     (m_status),
    .m_is_empty   (m_is_empty),
    .m_fill_count (m_fill_count)
);

`default_nettype wire
